/* rtl/vlbp_pkg.sv */
// Shared types and constants for the variable-length bit packer.
// No dependencies; every other file in this block imports it.
package vlbp_pkg;

  localparam int BYTE_BITS       = 8;
  localparam int CODE_FIELD_BITS = 20;
  localparam int LEN_W           = 5;
  // 7 pending bits plus a 20-bit code fit in four bytes.
  localparam int WORD_BITS       = 32;
  localparam int NBYTES_W        = 3;
  localparam int BIDX_W          = 2;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic ACT_APPEND = 1'b0;
  localparam logic ACT_FLUSH  = 1'b1;

  // One queued request: stream bits left-aligned, earliest bit in the MSB.
  typedef struct packed {
    logic [WORD_BITS-1:0] word;
    logic [NBYTES_W-1:0]  nbytes;
  } vlbp_entry_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } vlbp_qstat_t;

endpackage

/* rtl/vlbp_front.sv */
// Front end: accepts code words, merges them with the pending bits and
// hands whole/flushed bytes to the queue. Depends on vlbp_pkg.
module vlbp_front #(
  parameter int MAX_CODE_LEN = 20
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_action,
  input  logic [vlbp_pkg::CODE_FIELD_BITS-1:0] in_code_value,
  input  logic [vlbp_pkg::LEN_W-1:0]           in_code_len,
  input  vlbp_pkg::vlbp_qstat_t                q_stat,
  output logic                               push,
  output vlbp_pkg::vlbp_entry_t                push_entry
);
  import vlbp_pkg::*;

  localparam int LIM = (MAX_CODE_LEN < CODE_FIELD_BITS) ? MAX_CODE_LEN : CODE_FIELD_BITS;

  logic [BYTE_BITS-1:0]       pend_r, pend_nxt;
  logic [2:0]                 pc_r, pc_nxt;
  logic [LEN_W-1:0]           len_c;
  logic [CODE_FIELD_BITS-1:0] rev_code, keep_mask, code_top;
  logic [WORD_BITS-1:0]       word, shifted;
  logic [5:0]                 total;
  logic [2:0]                 nfull, rem;
  logic                       flush_now, accept;

  always_comb begin
    for (int i = 0; i < CODE_FIELD_BITS; i++) begin
      rev_code[CODE_FIELD_BITS-1-i] = in_code_value[i];
    end
  end

  assign len_c     = (in_code_len > LEN_W'(LIM)) ? LEN_W'(LIM) : in_code_len;
  assign keep_mask = ~({CODE_FIELD_BITS{1'b1}} >> len_c);
  assign code_top  = rev_code & keep_mask;
  // Pending bits on top, new code bits right behind them.
  assign word = {pend_r, {(WORD_BITS-BYTE_BITS){1'b0}}}
              | ({code_top, {(WORD_BITS-CODE_FIELD_BITS){1'b0}}} >> pc_r);
  assign total     = {3'b000, pc_r} + {1'b0, len_c};
  assign nfull     = total[5:3];
  assign rem       = total[2:0];
  assign flush_now = (in_action == ACT_FLUSH) && (rem != 3'd0);
  assign shifted   = word << {nfull, 3'b000};

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;

  assign push_entry.word   = word;
  assign push_entry.nbytes = nfull + {2'b00, flush_now};
  assign push              = accept && (push_entry.nbytes != '0);

  always_comb begin
    pend_nxt = pend_r;
    pc_nxt   = pc_r;
    if (accept) begin
      if (in_action == ACT_FLUSH) begin
        pend_nxt = '0;
        pc_nxt   = '0;
      end else begin
        pend_nxt = shifted[WORD_BITS-1 -: BYTE_BITS];
        pc_nxt   = rem;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      pc_r   <= '0;
    end else begin
      pend_r <= pend_nxt;
      pc_r   <= pc_nxt;
    end
  end

endmodule

/* rtl/vlbp_queue.sv */
// Short request queue between front and back end.
// Depends on vlbp_pkg for the entry type.
module vlbp_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  vlbp_pkg::vlbp_entry_t push_entry,
  input  logic                  pop,
  output vlbp_pkg::vlbp_entry_t head,
  output vlbp_pkg::vlbp_qstat_t stat
);
  import vlbp_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  vlbp_entry_t        mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  assign head       = mem[rd_ptr_r];
  assign stat.full  = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign stat.empty = (cnt_r == '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

/* rtl/vlbp_back.sv */
// Back end: walks the bytes of the head request into the output register.
// Depends on vlbp_pkg.
module vlbp_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  vlbp_pkg::vlbp_entry_t          head,
  input  vlbp_pkg::vlbp_qstat_t          q_stat,
  output logic                           pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [vlbp_pkg::BYTE_BITS-1:0] out_byte,
  output logic                           out_last_of_run
);
  import vlbp_pkg::*;

  logic                 out_valid_r;
  logic [BYTE_BITS-1:0] out_byte_r;
  logic                 last_r;
  logic [BIDX_W-1:0]    idx_r;
  logic [WORD_BITS-1:0] sel_word;
  logic                 load, is_last;

  assign load     = !q_stat.empty && (!out_valid_r || out_ready);
  assign sel_word = head.word << {idx_r, 3'b000};
  assign is_last  = ({1'b0, idx_r} + 1'b1) == head.nbytes;
  assign pop      = load && is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else if (load) begin
      out_valid_r <= 1'b1;
      idx_r       <= is_last ? '0 : idx_r + 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= sel_word[WORD_BITS-1 -: BYTE_BITS];
      last_r     <= is_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_last_of_run = last_r;

endmodule

/* rtl/variable_length_bit_packer.sv */
// Variable-length bit packer: appends 0..20-bit codes (LSB of the code first) to a
// bit stream and emits it as bytes, earliest bit in bit 7, zero padding a flushed
// tail. The front end takes one item per cycle while its two-entry queue has room;
// the back end emits one byte per cycle while out_ready does not stall it, and an
// item yields 0 to 4 bytes (at most 3 full bytes per item), so the sustained
// rate is set by the byte count through the output register.
// Depends on vlbp_pkg, vlbp_front, vlbp_queue and vlbp_back.
module variable_length_bit_packer #(
  parameter int MAX_CODE_LEN = 20
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_action,
  input  logic [vlbp_pkg::CODE_FIELD_BITS-1:0] in_code_value,
  input  logic [vlbp_pkg::LEN_W-1:0]           in_code_len,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [vlbp_pkg::BYTE_BITS-1:0]       out_byte,
  output logic                                 out_last_of_run
);
  import vlbp_pkg::*;

  vlbp_entry_t push_entry, head;
  vlbp_qstat_t q_stat;
  logic        push, pop;

  vlbp_front #(
    .MAX_CODE_LEN(MAX_CODE_LEN)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_action    (in_action),
    .in_code_value(in_code_value),
    .in_code_len  (in_code_len),
    .q_stat       (q_stat),
    .push         (push),
    .push_entry   (push_entry)
  );

  vlbp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_entry(push_entry),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  vlbp_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .q_stat         (q_stat),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_last_of_run(out_last_of_run)
  );

endmodule

/* rtl/vlbp_checker.sv */
// Port-level checks for variable_length_bit_packer, bound to the top level.
// Depends on vlbp_pkg for widths.
module vlbp_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic                                 in_action,
  input logic [vlbp_pkg::CODE_FIELD_BITS-1:0] in_code_value,
  input logic [vlbp_pkg::LEN_W-1:0]           in_code_len,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic [vlbp_pkg::BYTE_BITS-1:0]       out_byte,
  input logic                                 out_last_of_run
);
  import vlbp_pkg::*;

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last_of_run))
    else $error("result changed while stalled");

  // Hold a stalled request.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_action) && $stable(in_code_value)
      && $stable(in_code_len))
    else $error("request changed while stalled");

  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Queue is empty out of reset, so requests are taken at once.
  a_rst_ready: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> in_ready)
    else $error("input not ready after reset");

  // With no request taken right after reset, the two-entry queue stays empty, so input stays ready.
  a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) && !(in_valid && in_ready) |=> in_ready)
    else $error("input stalled with one request at most queued");

endmodule

bind variable_length_bit_packer vlbp_checker u_vlbp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_action      (in_action),
  .in_code_value  (in_code_value),
  .in_code_len    (in_code_len),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_byte       (out_byte),
  .out_last_of_run(out_last_of_run)
);

/* test/tb_variable_length_bit_packer.sv */
// Testbench for variable_length_bit_packer: randomized code requests with a
// local bit-stream predictor and a byte-by-byte check of the packed output.
// Depends on vlbp_pkg and the variable_length_bit_packer RTL.
`timescale 1ns / 1ps

module tb_variable_length_bit_packer;
  import vlbp_pkg::*;

  localparam int          CODE_CAP    = 20;
  localparam int          N_RANDOM    = 400;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int          EPOCH       = 300;

  typedef struct {
    logic                       action;
    logic [CODE_FIELD_BITS-1:0] value;
    logic [LEN_W-1:0]           len;
  } code_req_t;

  typedef struct {
    logic [BYTE_BITS-1:0] data;
    logic                 last;
  } packed_byte_t;

  logic                       clk             = 1'b0;
  logic                       rst_n           = 1'b0;
  logic                       in_valid        = 1'b0;
  logic                       in_ready;
  logic                       in_action       = ACT_APPEND;
  logic [CODE_FIELD_BITS-1:0] in_code_value   = '0;
  logic [LEN_W-1:0]           in_code_len     = '0;
  logic                       out_valid;
  logic                       out_ready       = 1'b0;
  logic [BYTE_BITS-1:0]       out_byte;
  logic                       out_last_of_run;

  code_req_t    code_req_q[$];
  packed_byte_t byte_expect_q[$];
  code_req_t    req_now;
  packed_byte_t byte_want;

  logic [WORD_BITS-1:0] stream_bits  = '0;
  int unsigned          stream_count = 0;

  int          reqs_total    = 0;
  int          reqs_accepted = 0;
  int          fail_count    = 0;
  int unsigned cycle_count   = 0;
  int unsigned in_gap_left   = 0;
  int unsigned out_stall_left = 0;
  int unsigned in_mode       = 0;
  int unsigned out_mode      = 0;

  variable_length_bit_packer i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_code_value   (in_code_value),
    .in_code_len     (in_code_len),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run)
  );

  always #5 clk = ~clk;

  task automatic queue_code(input logic act, input logic [CODE_FIELD_BITS-1:0] val,
                            input int unsigned len);
    code_req_t r;
    r.action = act;
    r.value  = val;
    r.len    = len[LEN_W-1:0];
    code_req_q.push_back(r);
    reqs_total++;
  endtask

  function automatic int unsigned rand_len();
    if ($urandom_range(0, 99) < 15) return $urandom_range(21, 31);
    return $urandom_range(0, CODE_CAP);
  endfunction

  // Mode 0 never idles, mode 1 idles lightly, mode 2 heavily.
  function automatic int unsigned pick_gap(input int unsigned mode);
    if (mode == 0) return 0;
    if ($urandom_range(0, 99) >= ((mode == 1) ? 25 : 60)) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // Append the code bits (LSB first), emit full bytes, then the padded tail on flush.
  task automatic pack_code(input code_req_t r);
    int unsigned          n;
    int                   first_idx;
    logic [WORD_BITS-1:0] shifted;
    packed_byte_t         b;
    n = (r.len > CODE_CAP) ? CODE_CAP : r.len;
    for (int i = 0; i < n; i++) begin
      stream_bits = {stream_bits[WORD_BITS-2:0], r.value[i]};
      stream_count++;
    end
    first_idx = byte_expect_q.size();
    b.last = 1'b0;
    while (stream_count >= BYTE_BITS) begin
      shifted = stream_bits >> (stream_count - BYTE_BITS);
      b.data = shifted[BYTE_BITS-1:0];
      byte_expect_q.push_back(b);
      stream_count -= BYTE_BITS;
      stream_bits &= (32'h1 << stream_count) - 1;
    end
    if (r.action == ACT_FLUSH && stream_count > 0) begin
      shifted = stream_bits << (BYTE_BITS - stream_count);
      b.data = shifted[BYTE_BITS-1:0];
      byte_expect_q.push_back(b);
      stream_count = 0;
      stream_bits = '0;
    end
    if (byte_expect_q.size() > first_idx)
      byte_expect_q[byte_expect_q.size()-1].last = 1'b1;
  endtask

  task automatic log_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("[%0t] ERROR: %s", $realtime, msg);
  endtask

  // Pick fresh idle modes for both sides now and then.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count % EPOCH == 0) begin
      in_mode  = $urandom_range(0, 2);
      out_mode = $urandom_range(0, 2);
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("variable_length_bit_packer regression: fail");
      $finish;
    end
  end

  // Request driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        pack_code(req_now);
        reqs_accepted++;
      end
      // Hold the payload until the request is taken.
      if (!(in_valid && !in_ready)) begin
        if (in_gap_left > 0) begin
          in_gap_left--;
          in_valid <= 1'b0;
        end else if (code_req_q.size() > 0) begin
          req_now = code_req_q.pop_front();
          in_valid      <= 1'b1;
          in_action     <= req_now.action;
          in_code_value <= req_now.value;
          in_code_len   <= req_now.len;
          in_gap_left = pick_gap(in_mode);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Byte monitor and output stall.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (byte_expect_q.size() == 0) begin
          log_failure($sformatf("unexpected byte %02h last %0b", out_byte, out_last_of_run));
        end else begin
          byte_want = byte_expect_q.pop_front();
          if (out_byte !== byte_want.data || out_last_of_run !== byte_want.last)
            log_failure($sformatf("byte exp %02h last %0b, got %02h last %0b",
                                  byte_want.data, byte_want.last, out_byte,
                                  out_last_of_run));
        end
      end
      if (out_stall_left > 0) begin
        out_stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_stall_left = pick_gap(out_mode);
        if (out_stall_left > 0) begin
          out_stall_left--;
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  initial begin
    int unsigned k;
    // An empty append and a flush with nothing pending.
    queue_code(ACT_APPEND, 20'h00000, 0);
    queue_code(ACT_FLUSH,  20'hFFFFF, 0);
    // Full-length codes, all ones and all zeros.
    queue_code(ACT_APPEND, 20'hFFFFF, 20);
    queue_code(ACT_FLUSH,  20'h00000, 20);
    // Seven pending bits plus twenty: three bytes and a flushed tail.
    queue_code(ACT_APPEND, 20'hFFF55, 7);
    queue_code(ACT_FLUSH,  20'hA5A5A, 20);
    // Oversized lengths saturate.
    queue_code(ACT_APPEND, 20'hFFFFF, 31);
    queue_code(ACT_APPEND, 20'h12345, 21);
    // Bits above the length are ignored; flush a short tail with a zero-length code.
    queue_code(ACT_APPEND, 20'hFFFF5, 3);
    queue_code(ACT_FLUSH,  20'hFFFFF, 0);
    queue_code(ACT_FLUSH,  20'h00001, 1);
    queue_code(ACT_FLUSH,  20'h000FF, 8);
    queue_code(ACT_APPEND, 20'hF0F0F, 16);
    queue_code(ACT_FLUSH,  20'h6C3A9, 24);
    queue_code(ACT_FLUSH,  20'hFFFFF, 31);
    queue_code(ACT_APPEND, 20'h80000, 20);
    queue_code(ACT_FLUSH,  20'h7FFFF, 19);
    queue_code(ACT_FLUSH,  20'h00000, 0);
    // Random runs of appends closed by a flush, with some stray flushes.
    while (reqs_total < N_RANDOM + 18) begin
      k = $urandom_range(0, 7);
      for (int i = 0; i < k; i++)
        queue_code(ACT_APPEND, CODE_FIELD_BITS'($urandom()),
                   ($urandom_range(0, 9) == 0) ? 0 : rand_len());
      queue_code(ACT_FLUSH, CODE_FIELD_BITS'($urandom()), rand_len());
      if ($urandom_range(0, 5) == 0) queue_code(ACT_FLUSH, CODE_FIELD_BITS'($urandom()), 0);
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (reqs_accepted < reqs_total || byte_expect_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("variable_length_bit_packer regression: pass");
    end else begin
      $display("variable_length_bit_packer regression: fail");
    end
    $finish;
  end

endmodule
